// File: rtl/taylor_sine_cosine_top_assert.svh
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top assertion macros
// Shorthand for clocked implication checks with an asynchronous low reset.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_COSINE_TOP_ASSERT_SVH
`define TAYLOR_SINE_COSINE_TOP_ASSERT_SVH

// same-cycle implication
`define TSC_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSC_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the Taylor sine/cosine block.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int MAX_TERMS_DEF = 12;

	localparam int MAG_W  = 64;   // term magnitude, Q8.56
	localparam int ACC_W  = 64;   // signed running sum, Q8.56
	localparam int PROD_W = 128;  // full product

	// item handed from one term cell to the next
	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [ACC_W-1:0] acc;
	} link_t;

	// final sum reported by the cell holding the last term
	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] acc;
	} fin_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQ,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

// File: rtl/tsc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_cell
// One term of the series: adds its term into the running sum, then forms the
// next term as round(round(term * x^2 / 2^58) * R(d) / 2^63) on a 32x32
// multiplier, four partial products per multiplication, and hands it on; at the last term it reports the sum.
// ----------------------------------------------------------------------------
module tsc_cell #(
	parameter int IDX = 0,
	parameter int CW  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsc_pkg::link_t      lnk_i,
	input  logic                cosine,
	input  logic [63:0]         x2,
	input  logic [CW-1:0]       n,
	output tsc_pkg::link_t      lnk_o,
	output tsc_pkg::fin_t       fin
);

	localparam logic [63:0] D_SIN   = 64'((2 * IDX + 2) * (2 * IDX + 3));
	localparam logic [63:0] D_COS   = 64'((2 * IDX + 1) * (2 * IDX + 2));
	localparam logic [63:0] RCP_SIN = (64'h8000_0000_0000_0000 + (D_SIN >> 1)) / D_SIN;
	localparam logic [63:0] RCP_COS = (64'h8000_0000_0000_0000 + (D_COS >> 1)) / D_COS;
	localparam logic [CW-1:0] IDX_NEXT = CW'(IDX + 1);
	localparam logic [2:0] FIN_STEP = 3'd4;

	logic        busy_q, ph_q, hand_q, fin_q, neg_q;
	logic [2:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [127:0] prod_q;

	logic         more;
	logic [63:0]  b_op;
	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [1:0]   word_sh;
	logic [127:0] pp_sh;
	logic [127:0] rnd;
	logic [63:0]  res;

	assign more = IDX_NEXT < n;

	assign b_op   = ph_q ? (cosine ? RCP_COS : RCP_SIN) : x2;
	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_op[63:32] : b_op[31:0];
	assign pp     = a_part * b_part;
	assign word_sh = {cnt_q[1] & cnt_q[0], cnt_q[1] ^ cnt_q[0]};
	assign pp_sh  = {64'd0, pp} << {word_sh, 5'd0};

	// round half up, then saturate to 64 bits
	assign rnd = prod_q + (ph_q ? (128'd1 << 62) : (128'd1 << 57));
	always_comb begin
		if (ph_q) begin
			res = rnd[127] ? '1 : rnd[126:63];
		end else begin
			res = (|rnd[127:122]) ? '1 : rnd[121:58];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
			hand_q <= 1'b0;
			fin_q  <= 1'b0;
		end else begin
			hand_q <= 1'b0;
			fin_q  <= 1'b0;
			if (lnk_i.valid) begin
				if (more) begin
					busy_q <= 1'b1;
					ph_q   <= 1'b0;
					cnt_q  <= '0;
				end else begin
					fin_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == FIN_STEP) begin
					cnt_q <= '0;
					if (ph_q) begin
						busy_q <= 1'b0;
						hand_q <= 1'b1;
					end else begin
						ph_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_i.valid) begin
			a_q    <= lnk_i.mag;
			neg_q  <= lnk_i.neg;
			acc_q  <= lnk_i.neg ? (lnk_i.acc - lnk_i.mag) : (lnk_i.acc + lnk_i.mag);
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == FIN_STEP) begin
				a_q    <= res;
				prod_q <= '0;
			end else begin
				prod_q <= prod_q + pp_sh;
			end
		end
	end

	assign lnk_o.valid = hand_q;
	assign lnk_o.neg   = ~neg_q;
	assign lnk_o.mag   = a_q;
	assign lnk_o.acc   = acc_q;

	assign fin.valid = fin_q;
	assign fin.acc   = acc_q;

endmodule

// File: rtl/taylor_sine_cosine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Truncated Taylor series for sine (action 0) or cosine (action 1) of a
// signed Q2.29 angle, result in signed Q7.24, rounded and saturated. The sum
// runs over term_count terms (clamped to MAX_TERMS; zero terms give zero).
// Terms move down a row of cells, one cell per term; each cell forms the next
// term with two 64x64 multiplications done as four 32x32 partial products
// apiece. Items are worked one at a time: the next item is taken only once
// the result of the last one has been loaded into the output register. A
// finished result sits in the output register while the next item is taken
// in; a result still waiting there holds back the one after it.
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_top_assert.svh"

module taylor_sine_cosine_top #(
	parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  term_count,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic signed [31:0] angle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] approximation
);

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;

	tsc_pkg::state_t state_q, state_nxt;

	logic [3:0]    term_count_q;
	logic          cos_q, xneg_q;
	logic [31:0]   xmag_q;
	logic [63:0]   x2_q;
	logic [CW-1:0] n_q, n_clamp;
	logic [63:0]   res_acc_q;
	logic          out_valid_q;
	logic [31:0]   approx_q;

	logic          accept, launch, load_out;
	logic [63:0]   sq;

	tsc_pkg::link_t lnk [0:MAX_TERMS];
	tsc_pkg::fin_t  fin [0:MAX_TERMS-1];
	logic [MAX_TERMS-1:0] fin_vec;
	logic          fin_any;
	logic [63:0]   fin_acc;

	logic [63:0]   amag;
	logic [32:0]   q, qs;
	logic [31:0]   res;

	// configuration
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= 4'd6;
		end else if (cfg_valid && cfg_ready) begin
			term_count_q <= term_count;
		end
	end

	assign n_clamp = (int'(term_count_q) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(term_count_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tsc_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = tsc_pkg::ST_SQ;
			end
			tsc_pkg::ST_SQ: begin
				state_nxt = (n_q == '0) ? tsc_pkg::ST_DONE : tsc_pkg::ST_RUN;
			end
			tsc_pkg::ST_RUN: begin
				if (fin_any) state_nxt = tsc_pkg::ST_DONE;
			end
			tsc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_nxt = tsc_pkg::ST_IDLE;
			end
			default: state_nxt = tsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		launch   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			tsc_pkg::ST_IDLE: in_ready = 1'b1;
			tsc_pkg::ST_SQ:   launch   = (n_q != '0);
			tsc_pkg::ST_RUN:  ;
			tsc_pkg::ST_DONE: load_out = !out_valid_q || out_ready;
			default:          ;
		endcase
	end

	assign accept = in_valid && in_ready;

	// operand capture and square
	assign sq = xmag_q * xmag_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			cos_q  <= action;
			xneg_q <= angle[31];
			xmag_q <= angle[31] ? (~angle + 32'd1) : angle;
			n_q    <= n_clamp;
		end
		if (state_q == tsc_pkg::ST_SQ) begin
			x2_q <= sq;
		end
		if (state_q == tsc_pkg::ST_SQ && n_q == '0) begin
			res_acc_q <= '0;
		end else if (fin_any) begin
			res_acc_q <= fin_acc;
		end
	end

	// row of term cells
	assign lnk[0].valid = launch;
	assign lnk[0].neg   = cos_q ? 1'b0 : xneg_q;
	assign lnk[0].mag   = cos_q ? ONE_Q56 : {5'd0, xmag_q, 27'd0};
	assign lnk[0].acc   = '0;

	for (genvar gi = 0; gi < MAX_TERMS; gi++) begin : g_cell
		tsc_cell #(
			.IDX (gi),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.lnk_i  (lnk[gi]),
			.cosine (cos_q),
			.x2     (x2_q),
			.n      (n_q),
			.lnk_o  (lnk[gi+1]),
			.fin    (fin[gi])
		);
		assign fin_vec[gi] = fin[gi].valid;
	end

	always_comb begin
		fin_acc = '0;
		for (int i = 0; i < MAX_TERMS; i++) begin
			if (fin[i].valid) fin_acc = fin_acc | fin[i].acc;
		end
	end
	assign fin_any = |fin_vec;

	// round half away from zero to Q7.24, saturate
	assign amag = res_acc_q[63] ? (~res_acc_q + 64'd1) : res_acc_q;
	assign q    = {1'b0, amag[63:32]} + {32'd0, amag[31]};
	always_comb begin
		if (res_acc_q[63]) begin
			qs  = (q > 33'h0_8000_0000) ? 33'h0_8000_0000 : q;
			res = ~qs[31:0] + 32'd1;
		end else begin
			qs  = (q > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : q;
			res = qs[31:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) approx_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign approximation = approx_q;

	`TSC_ASSERT_IMP(a_chain_end, clk, arst_n, 1'b1, !lnk[MAX_TERMS].valid, "term passed last cell")
	`TSC_ASSERT_IMP(a_fin_one, clk, arst_n, 1'b1, $onehot0(fin_vec), "two cells finished at once")
	`TSC_ASSERT_IMP(a_fin_run, clk, arst_n, fin_any, state_q == tsc_pkg::ST_RUN, "sum outside run")
	`TSC_ASSERT_NXT(a_acc_sq, clk, arst_n, accept, state_q == tsc_pkg::ST_SQ, "item not squared")

endmodule

// File: tb/sv/taylor_sine_cosine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top_test
// Self-checking bench for the Taylor sine/cosine block. A directed table
// (term count extremes, angle extremes, zero and clamped term counts) is
// followed by random phases, each with its own term count. Every accepted
// angle is predicted by the table or a bit-exact fixed-point series sum and
// compared with the next approximation out. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_top_test;

	localparam logic ACT_SINE   = 1'b0;
	localparam logic ACT_COSINE = 1'b1;

	localparam int          TERMS_RESET   = 6;
	localparam int          MAX_GAP       = 18;
	localparam int          LONG_HOLD     = 400;
	localparam int          TAIL_CYCLES   = 200;
	localparam int          PHASES        = 10;
	localparam int          PHASE_ITEMS   = 60;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [3:0]  terms;
		logic        act;
		logic [31:0] ang;
		logic        known;
		logic [31:0] result;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  term_count = 4'(TERMS_RESET);
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ACT_SINE;
	logic [31:0] angle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] approximation;

	logic [31:0] expected_sums [$];
	logic [3:0]  terms_now = 4'(TERMS_RESET);
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	logic        burst = 1'b0;
	logic        rx_hold_req = 1'b0;
	logic        rx_holding = 1'b0;

	dir_row_t dir_rows [21] = '{
		'{4'd6,  ACT_COSINE, 32'h0000_0000, 1'b1, 32'h0100_0000},
		'{4'd6,  ACT_SINE,   32'h0000_0000, 1'b1, 32'h0000_0000},
		'{4'd6,  ACT_SINE,   32'h7FFF_FFFF, 1'b0, 32'h0},
		'{4'd6,  ACT_SINE,   32'h8000_0000, 1'b0, 32'h0},
		'{4'd6,  ACT_COSINE, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{4'd6,  ACT_COSINE, 32'h8000_0000, 1'b0, 32'h0},
		'{4'd6,  ACT_SINE,   32'h0000_0001, 1'b0, 32'h0},
		'{4'd6,  ACT_SINE,   32'hFFFF_FFFF, 1'b0, 32'h0},
		'{4'd6,  ACT_COSINE, 32'h2000_0000, 1'b0, 32'h0},
		'{4'd6,  ACT_SINE,   32'hE000_0000, 1'b0, 32'h0},
		'{4'd0,  ACT_SINE,   32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
		'{4'd0,  ACT_COSINE, 32'h8000_0000, 1'b1, 32'h0000_0000},
		'{4'd1,  ACT_COSINE, 32'h1234_5678, 1'b1, 32'h0100_0000},
		'{4'd1,  ACT_SINE,   32'h2000_0000, 1'b1, 32'h0100_0000},
		'{4'd1,  ACT_SINE,   32'h8000_0000, 1'b1, 32'hFC00_0000},
		'{4'd12, ACT_SINE,   32'h7FFF_FFFF, 1'b0, 32'h0},
		'{4'd12, ACT_COSINE, 32'h8000_0000, 1'b0, 32'h0},
		'{4'd12, ACT_SINE,   32'h3243_F6A9, 1'b0, 32'h0},
		'{4'd12, ACT_COSINE, 32'h3243_F6A9, 1'b0, 32'h0},
		'{4'd15, ACT_SINE,   32'h8000_0000, 1'b0, 32'h0},
		'{4'd13, ACT_COSINE, 32'h0000_0000, 1'b1, 32'h0100_0000}
	};

	taylor_sine_cosine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.term_count    (term_count),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.angle         (angle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.approximation (approximation)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// round(a*b / 2^s), saturated to 64 bits
	function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
			input int unsigned s);
		logic [128:0] p;
		p = 129'(a) * 129'(b) + (129'(1) << (s - 1));
		p = p >> s;
		return (p[128:64] != '0) ? '1 : p[63:0];
	endfunction

	// Q0.63 reciprocal of the divisor, rounded
	function automatic logic [63:0] rom_reciprocal(input logic [63:0] d);
		return ((64'd1 << 63) + d / 2) / d;
	endfunction

	function automatic logic [31:0] series_sum(input logic act, input logic [31:0] x,
			input logic [3:0] terms);
		logic        xneg;
		logic        tneg;
		logic        aneg;
		logic [31:0] xmag;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] amag;
		logic [63:0] q;
		logic [63:0] d;
		int unsigned n;
		int unsigned i;
		xneg = x[31];
		xmag = xneg ? -x : x;
		x2 = 64'(xmag) * 64'(xmag);
		n = (terms > tsc_pkg::MAX_TERMS_DEF) ? tsc_pkg::MAX_TERMS_DEF : terms;
		term = (act == ACT_COSINE) ? (64'd1 << 56) : (64'(xmag) << 27);
		tneg = (act == ACT_COSINE) ? 1'b0 : xneg;
		acc = '0;
		for (i = 0; i < n; i++) begin
			acc = tneg ? acc - term : acc + term;
			if (i + 1 < n) begin
				d = (act == ACT_COSINE) ? 64'((2 * i + 1) * (2 * i + 2))
				                        : 64'((2 * i + 2) * (2 * i + 3));
				term = scaled_product(term, x2, 58);
				term = scaled_product(term, rom_reciprocal(d), 63);
				tneg = !tneg;
			end
		end
		aneg = acc[63];
		amag = aneg ? -acc : acc;
		q = (amag >> 32) + 64'(amag[31]);
		if (aneg) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return -q[31:0];
		end else begin
			if (q > 64'h7FFF_FFFF)
				q = 64'h7FFF_FFFF;
			return q[31:0];
		end
	endfunction

	function automatic logic [31:0] draw_angle();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 512)) - 256);
			default: return $urandom;
		endcase
	endfunction

	// offer one angle; valid stays up after acceptance until the next call decides
	task automatic send_angle(input logic act, input logic [31:0] ang, input logic known,
			input logic [31:0] result);
		int unsigned gap;
		logic [31:0] sum;
		gap = (burst || rx_hold_req || rx_holding) ? 0 : $urandom_range(0, MAX_GAP);
		sum = known ? result : series_sum(act, ang, terms_now);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		angle <= ang;
		do @(posedge clk); while (!in_ready);
		expected_sums.push_back(sum);
	endtask

	// drop valid and wait until every outstanding result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_sums.size() != 0);
	endtask

	task automatic write_term_count(input logic [3:0] terms);
		cfg_valid <= 1'b1;
		term_count <= terms;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		terms_now = terms;
	endtask

	// result side
	initial begin
		int unsigned hold;
		logic [31:0] due;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				rx_holding = 1'b1;
				hold = LONG_HOLD;
			end else begin
				hold = burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rx_holding = 1'b0;
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_sums.size() == 0) begin
				$error("approximation: no result expected, got %h", approximation);
				fail_count++;
			end else begin
				due = expected_sums.pop_front();
				if (approximation !== due) begin
					$error("approximation: expected %h, got %h", due, approximation);
					fail_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned ph;
		int unsigned k;
		logic [3:0] phase_terms;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].terms != terms_now) begin
				drain_results();
				write_term_count(dir_rows[r].terms);
			end
			send_angle(dir_rows[r].act, dir_rows[r].ang, dir_rows[r].known, dir_rows[r].result);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_terms = 4'd12;
				1: phase_terms = 4'd0;
				2: phase_terms = 4'd15;
				3: phase_terms = 4'd6;
				default: phase_terms = 4'($urandom_range(0, 15));
			endcase
			drain_results();
			write_term_count(phase_terms);
			burst = (ph % 4 == 2);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// long receiver stall while angles keep coming
				if (ph == 3 && k == 15)
					rx_hold_req = 1'b1;
				// sender waits for the pipeline to empty mid-phase
				if (ph == 6 && k == 30)
					drain_results();
				send_angle($urandom_range(0, 1) ? ACT_COSINE : ACT_SINE, draw_angle(),
					1'b0, 32'h0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_cell.sv
rtl/taylor_sine_cosine_top.sv
tb/sv/taylor_sine_cosine_top_test.sv
